// ===== hdl/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared sizes, codes and the request record of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int NUM_CORES   = 4;
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_THREADS = 256;
  localparam int NUM_PRIOS   = 5;

  localparam int NUM_Q  = NUM_CORES * NUM_PRIOS;
  localparam int Q_W    = $clog2(NUM_Q);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SA_W   = $clog2(NUM_Q * QUEUE_DEPTH);
  localparam int TH_W   = $clog2(NUM_THREADS);
  localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  localparam int CMD_W  = 2;
  localparam int TID_W  = 8;
  localparam int PRIO_W = 3;
  localparam int CNUM_W = 3;
  localparam int ST_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_PICK  = 2'd1,
    CMD_BLOCK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_PICK,
    OP_BLOCK,
    OP_NOP
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_PRIO = 2'd1,
    ST_FULL = 2'd2
  } st_e;

  typedef struct packed {
    op_e                op;
    logic [TID_W-1:0]   tid;
    logic               tid_bad;
    logic               prio_bad;
    logic [Q_W-1:0]     q;
    logic [CORE_W-1:0]  qc;
    logic [CNUM_W-1:0]  core;
  } req_t;

endpackage

// ===== hdl/rqs_front.sv =====
// ----------------------------------------------------------------------------
// rqs_front
// Accepts commands, decodes them into requests and buffers two of them.
// ----------------------------------------------------------------------------
module rqs_front import rqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [TID_W-1:0]   thread_num_i,
  input  logic [PRIO_W-1:0]  prio_level_i,
  input  logic [CNUM_W-1:0]  core_num_i,
  output logic               req_valid_o,
  input  logic               req_pop_i,
  output req_t               req_o
);

  req_t              dec;
  req_t              fifo_q [2];
  logic              wptr_q;
  logic              rptr_q;
  logic [1:0]        cnt_q;
  logic              push;
  logic              pop;

  always_comb begin
    dec          = '0;
    dec.tid      = thread_num_i;
    dec.core     = core_num_i;
    dec.tid_bad  = (32'(thread_num_i) >= NUM_THREADS);
    dec.prio_bad = (32'(prio_level_i) >= NUM_PRIOS);
    // out-of-range core falls back to core 0
    dec.qc       = (32'(core_num_i) < NUM_CORES) ? CORE_W'(core_num_i) : '0;
    dec.q        = Q_W'(32'(dec.qc) * NUM_PRIOS + 32'(prio_level_i));
    case (cmd_i)
      CMD_ENQ:   dec.op = OP_ENQ;
      CMD_PICK:  dec.op = OP_PICK;
      CMD_BLOCK: dec.op = OP_BLOCK;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_pop_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/rqs_back.sv =====
// ----------------------------------------------------------------------------
// rqs_back
// Executes requests against the ring queues and thread table; holds result.
// ----------------------------------------------------------------------------
module rqs_back import rqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_pop_o,
  input  req_t               req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [TID_W-1:0]   picked_thread_o,
  output logic               idle_chosen_o,
  output logic [ST_W-1:0]    status_o
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_CHECK} state_e;

  state_e              state_q;
  logic [IDX_W-1:0]    head_q [NUM_Q];
  logic [IDX_W-1:0]    tail_q [NUM_Q];
  logic [CNT_W-1:0]    cnt_q  [NUM_Q];
  logic                ready_q [NUM_THREADS];
  logic [TID_W-1:0]    store_q [NUM_Q * QUEUE_DEPTH];
  logic [CNUM_W-1:0]   core_mem_q [NUM_THREADS];
  logic [TID_W-1:0]    store_rd_q;
  logic [CNUM_W-1:0]   core_rd_q;
  logic                ready_rd_q;
  logic [TID_W-1:0]    tid_q;
  logic [CORE_W-1:0]   qc_q;
  logic [PRIO_W-1:0]   p_q;
  logic                out_valid_q;
  logic                acc_q;
  logic [TID_W-1:0]    pick_q;
  logic                idle_q;
  logic [ST_W-1:0]     st_q;

  logic                take;
  logic [Q_W-1:0]      sel;
  logic [IDX_W-1:0]    head_rd;
  logic [IDX_W-1:0]    tail_rd;
  logic [CNT_W-1:0]    cnt_rd;
  logic [SA_W-1:0]     sa;
  logic                full;
  logic                store_we;
  logic                store_re;
  logic                core_re;
  logic                runnable;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign take      = (state_q == S_IDLE) && req_valid_i && (!out_valid_q || out_ready_i);
  assign req_pop_o = take;

  assign sel     = (state_q == S_IDLE) ? req_i.q
                                       : Q_W'(32'(qc_q) * NUM_PRIOS + 32'(p_q));
  assign head_rd = head_q[sel];
  assign tail_rd = tail_q[sel];
  assign cnt_rd  = cnt_q[sel];
  assign full    = (cnt_rd == CNT_W'(QUEUE_DEPTH));
  assign sa      = SA_W'(32'(sel) * QUEUE_DEPTH
                       + 32'((state_q == S_IDLE) ? tail_rd : head_rd));

  assign store_we = take && (req_i.op == OP_ENQ) && !req_i.prio_bad
                    && !req_i.tid_bad && !full;
  assign store_re = (state_q == S_SCAN) && (cnt_rd != '0);
  assign core_re  = (state_q == S_READ);
  assign runnable = (32'(tid_q) < NUM_THREADS) && ready_rd_q
                    && (core_rd_q == CNUM_W'(qc_q));

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[sa] <= req_i.tid;
    if (store_re) store_rd_q <= store_q[sa];
  end

  always_ff @(posedge clk_i) begin
    if (store_we) core_mem_q[TH_W'(req_i.tid)] <= req_i.core;
    if (core_re)  core_rd_q <= core_mem_q[TH_W'(store_rd_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      cnt_q       <= '{default: '0};
      ready_q     <= '{default: 1'b0};
      ready_rd_q  <= 1'b0;
      tid_q       <= '0;
      qc_q        <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      pick_q      <= '0;
      idle_q      <= 1'b0;
      st_q        <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (take) begin
            out_valid_q <= (req_i.op != OP_PICK);
            pick_q      <= '0;
            idle_q      <= 1'b0;
            case (req_i.op)
              OP_ENQ: begin
                acc_q <= !req_i.prio_bad && !req_i.tid_bad && !full;
                st_q  <= req_i.prio_bad ? ST_PRIO
                       : (!req_i.tid_bad && full) ? ST_FULL : ST_OK;
                if (!req_i.prio_bad && !req_i.tid_bad && !full) begin
                  tail_q[sel]                <= idx_inc(tail_rd);
                  cnt_q[sel]                 <= cnt_rd + 1'b1;
                  ready_q[TH_W'(req_i.tid)]  <= 1'b1;
                end
              end
              OP_BLOCK: begin
                acc_q <= !req_i.tid_bad;
                st_q  <= ST_OK;
                if (!req_i.tid_bad) begin
                  ready_q[TH_W'(req_i.tid)] <= 1'b0;
                end
              end
              OP_PICK: begin
                acc_q   <= 1'b0;
                st_q    <= ST_OK;
                qc_q    <= req_i.qc;
                p_q     <= PRIO_W'(NUM_PRIOS - 1);
                state_q <= S_SCAN;
              end
              default: begin
                acc_q <= 1'b0;
                st_q  <= ST_OK;
              end
            endcase
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cnt_rd == '0) begin
            if (p_q == '0) begin
              out_valid_q <= 1'b1;
              idle_q      <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              p_q <= p_q - 1'b1;
            end
          end else begin
            // pop head now; the entry is judged in S_CHECK, after S_READ
            head_q[sel]   <= idx_inc(head_rd);
            cnt_q[sel]    <= cnt_rd - 1'b1;
            state_q       <= S_READ;
          end
        end
        S_READ: begin
          tid_q      <= store_rd_q;
          ready_rd_q <= ready_q[TH_W'(store_rd_q)];
          state_q    <= S_CHECK;
        end
        S_CHECK: begin
          if (runnable) begin
            ready_q[TH_W'(tid_q)] <= 1'b0;
            out_valid_q           <= 1'b1;
            acc_q                 <= 1'b1;
            pick_q                <= tid_q;
            state_q               <= S_IDLE;
          end else begin
            // drop stale entry, keep walking
            state_q <= S_SCAN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign picked_thread_o = pick_q;
  assign idle_chosen_o   = idle_q;
  assign status_o        = st_q;

endmodule

// ===== hdl/per_core_multilevel_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// per_core_multilevel_ready_queue_top
// Per-core, five-level ready-queue scheduler with enqueue, pick and block.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transaction:
//   enqueue, pick or block. Output channel (out_valid_o/out_ready_i) returns
//   exactly one result transaction per command, in command order.
//   A two-entry request queue decouples decode from execution, so commands
//   are taken while a result waits on a stalled receiver; when that queue is
//   full in_ready_o drops.
//   Execution: enqueue, block and unknown commands finish in the cycle they
//   leave the request queue, and their result is registered as they finish. A
//   pick steps past each empty priority level from the highest down and, for
//   each ring entry it pops, runs head pop, ring memory read and thread table
//   read before judging it; its result is registered once it picks or idles.
//   Reset clears all queue pointers and ready bits at once; no sweep is run.
//   A stalled receiver holds the result register and halts execution only.
// ----------------------------------------------------------------------------
module per_core_multilevel_ready_queue_top import rqs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [TID_W-1:0]   thread_num_i,
  input  logic [PRIO_W-1:0]  prio_level_i,
  input  logic [CNUM_W-1:0]  core_num_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [TID_W-1:0]   picked_thread_o,
  output logic               idle_chosen_o,
  output logic [ST_W-1:0]    status_o
);

  logic req_valid;
  logic req_pop;
  req_t req;

  rqs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .thread_num_i (thread_num_i),
    .prio_level_i (prio_level_i),
    .core_num_i   (core_num_i),
    .req_valid_o  (req_valid),
    .req_pop_i    (req_pop),
    .req_o        (req)
  );

  rqs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_pop_o       (req_pop),
    .req_i           (req),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .picked_thread_o (picked_thread_o),
    .idle_chosen_o   (idle_chosen_o),
    .status_o        (status_o)
  );

  a_idle_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_chosen_o |-> !accepted_o && (status_o == ST_OK)
                                      && (picked_thread_o == '0))
    else $error("idle result carries a thread or a status");

  a_error_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !accepted_o && !idle_chosen_o)
    else $error("rejected enqueue reported as accepted");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop |-> req_valid && (!out_valid_o || out_ready_i))
    else $error("request popped without result room");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Ready-queue scheduler testbench
// Drives random and directed enqueue, pick and block commands through the
// valid/ready input channel, predicts each result from a local copy of the
// queues and thread tables, and compares every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rqs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic [CNUM_W-1:0] core;
  } sched_cmd_t;

  typedef struct packed {
    logic             acc;
    logic [TID_W-1:0] pick;
    logic             idle;
    logic [ST_W-1:0]  st;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CMD_W-1:0] cmd_i = '0;
  logic [TID_W-1:0] thread_num_i = '0;
  logic [PRIO_W-1:0] prio_level_i = '0;
  logic [CNUM_W-1:0] core_num_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic accepted_o;
  logic [TID_W-1:0] picked_thread_o;
  logic idle_chosen_o;
  logic [ST_W-1:0] status_o;

  per_core_multilevel_ready_queue_top u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [TID_W-1:0] ring [NUM_Q][QUEUE_DEPTH];
  int unsigned qhead [NUM_Q];
  int unsigned qtail [NUM_Q];
  int unsigned qcnt [NUM_Q];
  bit ready_tbl [NUM_THREADS];
  logic [CNUM_W-1:0] bound_tbl [NUM_THREADS];
  bit bound_none [NUM_THREADS];

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_res[$];
  int errors = 0;
  int send_idle = 29;
  int recv_idle = 61;
  longint cycles = 0;

  function automatic sched_res_t predict_sched(sched_cmd_t c);
    sched_res_t r;
    int qc, q, t;
    r = '0;
    qc = (c.core < NUM_CORES) ? int'(c.core) : 0;
    case (c.cmd)
      CMD_ENQ: begin
        q = qc * NUM_PRIOS + int'(c.prio);
        if (c.prio >= NUM_PRIOS) r.st = ST_PRIO;
        else if (qcnt[q] >= QUEUE_DEPTH) r.st = ST_FULL;
        else begin
          ring[q][qtail[q]] = c.tid;
          qtail[q] = (qtail[q] + 1) % QUEUE_DEPTH;
          qcnt[q]++;
          ready_tbl[c.tid] = 1'b1;
          bound_tbl[c.tid] = c.core;
          bound_none[c.tid] = 1'b0;
          r.acc = 1'b1;
        end
      end
      CMD_PICK: begin
        r.idle = 1'b1;
        for (int p = NUM_PRIOS - 1; p >= 0 && r.idle; p--) begin
          q = qc * NUM_PRIOS + p;
          while (qcnt[q] > 0 && r.idle) begin
            t = int'(ring[q][qhead[q]]);
            qhead[q] = (qhead[q] + 1) % QUEUE_DEPTH;
            qcnt[q]--;
            if (!bound_none[t] && bound_tbl[t] == qc && ready_tbl[t]) begin
              ready_tbl[t] = 1'b0;
              r.acc = 1'b1;
              r.pick = TID_W'(t);
              r.idle = 1'b0;
            end
          end
        end
      end
      CMD_BLOCK: begin
        ready_tbl[c.tid] = 1'b0;
        r.acc = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        void'(pending_cmds.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the transaction
      end else if (pending_cmds.size() > 0 &&
                   $urandom_range(99) >= send_idle) begin
        sched_cmd_t c;
        c = pending_cmds[0];
        in_valid_i <= 1'b1;
        cmd_i <= c.cmd;
        thread_num_i <= c.tid;
        prio_level_i <= c.prio;
        core_num_i <= c.core;
        expected_res.push_back(predict_sched(c));
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result acc=%0d pick=%0d idle=%0d st=%0d", $time,
                 accepted_o, picked_thread_o, idle_chosen_o, status_o);
        errors++;
      end else begin
        sched_res_t e;
        e = expected_res.pop_front();
        if (accepted_o !== e.acc) begin
          $display("%0t: accepted exp %0d got %0d", $time, e.acc, accepted_o); errors++;
        end
        if (picked_thread_o !== e.pick) begin
          $display("%0t: picked_thread exp %0d got %0d", $time, e.pick, picked_thread_o);
          errors++;
        end
        if (idle_chosen_o !== e.idle) begin
          $display("%0t: idle_chosen exp %0d got %0d", $time, e.idle, idle_chosen_o); errors++;
        end
        if (status_o !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic sched_cmd_t mk(int cmd, int tid, int prio, int core);
    sched_cmd_t c;
    c.cmd = CMD_W'(cmd); c.tid = TID_W'(tid); c.prio = PRIO_W'(prio);
    c.core = CNUM_W'(core);
    return c;
  endfunction

  // random item, biased toward small thread pools so picks find real work
  function automatic sched_cmd_t rand_cmd();
    int k;
    int tid;
    k = $urandom_range(99);
    tid = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15);
    if (k < 45)
      return mk(CMD_ENQ, tid, ($urandom_range(9) == 0) ? $urandom_range(7)
                : $urandom_range(4), ($urandom_range(9) == 0) ? $urandom_range(7)
                : $urandom_range(3));
    else if (k < 80)
      return mk(CMD_PICK, $urandom_range(255), $urandom_range(7),
                ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3));
    else if (k < 95)
      return mk(CMD_BLOCK, tid, $urandom_range(7), $urandom_range(7));
    else
      return mk(CMD_UNUSED, $urandom_range(255), $urandom_range(7), $urandom_range(7));
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_res.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    for (int q = 0; q < NUM_Q; q++) begin
      qhead[q] = 0; qtail[q] = 0; qcnt[q] = 0;
    end
    for (int t = 0; t < NUM_THREADS; t++) begin
      ready_tbl[t] = 1'b0; bound_tbl[t] = '0; bound_none[t] = 1'b1;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty pick, extremes, out-of-range core, bad prio, duplicates
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ENQ, 255, 4, 3));
    pending_cmds.push_back(mk(CMD_ENQ, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_ENQ, 7, 5, 1));
    pending_cmds.push_back(mk(CMD_ENQ, 7, 7, 1));
    pending_cmds.push_back(mk(CMD_ENQ, 9, 2, 4));
    pending_cmds.push_back(mk(CMD_ENQ, 9, 2, 7));
    pending_cmds.push_back(mk(CMD_ENQ, 5, 1, 2));
    pending_cmds.push_back(mk(CMD_ENQ, 5, 3, 2));
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 3));
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 4));
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 2));
    pending_cmds.push_back(mk(CMD_PICK, 0, 0, 2));
    pending_cmds.push_back(mk(CMD_ENQ, 12, 0, 1));
    pending_cmds.push_back(mk(CMD_BLOCK, 12, 0, 0));
    pending_cmds.push_back(mk(CMD_BLOCK, 255, 7, 7));
    pending_cmds.push_back(mk(CMD_PICK, 255, 7, 1));
    pending_cmds.push_back(mk(CMD_UNUSED, 255, 7, 7));
    // fill one queue to overflow
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) pending_cmds.push_back(mk(CMD_ENQ, i, 4, 1));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(mk(CMD_PICK, 0, 0, 1));
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 460; i++) pending_cmds.push_back(rand_cmd());
      drain();
      if (ph == 0) begin send_idle = 61; recv_idle = 29; end
      else begin send_idle = 0; recv_idle = 0; end
    end
    // worst pick walks a full queue: allow a generous tail
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_res.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/rqs_pkg.sv
hdl/rqs_front.sv
hdl/rqs_back.sv
hdl/per_core_multilevel_ready_queue_top.sv
tb/sv/testbench.sv
